FILE: src/ovn3d_pkg.sv
// ============================================================================
// ovn3d_pkg: shared definitions for the octave value noise block
// Field widths, stream packing offsets, control codes and the cosine
// weight ROM that is built at elaboration.
// ============================================================================
`default_nettype none

package ovn3d_pkg;

   // Table and noise geometry
   localparam int TABLE_ADDR_BITS = 12;
   localparam int Y_SHIFT         = 4;
   localparam int Z_SHIFT         = 8;
   localparam int MAX_OCTAVES     = 8;
   localparam int COS_ROM_BITS    = 10;

   localparam int TABLE_DEPTH = 1 << TABLE_ADDR_BITS;
   localparam int ROM_DEPTH   = 1 << COS_ROM_BITS;

   // Field widths
   localparam int FRAC_BITS    = 16;
   localparam int VALUE_BITS   = 16;
   localparam int COORD_BITS   = 32;
   localparam int INDEX_BITS   = 12;
   localparam int OCT_BITS     = 4;
   localparam int FALLOFF_BITS = 16;
   localparam int NOISE_BITS   = 19;

   // Stream packing: table_index, table_value, coord_x, coord_y, coord_z
   localparam int IDX_LSB       = 0;
   localparam int VAL_LSB       = IDX_LSB + INDEX_BITS;
   localparam int X_LSB         = VAL_LSB + VALUE_BITS;
   localparam int Y_LSB         = X_LSB + COORD_BITS;
   localparam int Z_LSB         = Y_LSB + COORD_BITS;
   localparam int REQ_DATA_BITS = ((Z_LSB + COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((NOISE_BITS + 7) / 8) * 8;

   // Register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_SEL_BIT   = 2;

   localparam logic [OCT_BITS-1:0]     OCT_RESET     = 4'd4;
   localparam logic [FALLOFF_BITS-1:0] FALLOFF_RESET = 16'd32768;
   localparam logic [VALUE_BITS-1:0]   AMP_INIT      = 16'd32768;
   localparam logic [NOISE_BITS-1:0]   NOISE_MAX     = '1;

   // Accumulator holds up to MAX_OCTAVES products of two Q0.16 values.
   localparam int ACC_BITS = 2 * VALUE_BITS + $clog2(MAX_OCTAVES);
   localparam int SUM_BITS = (ACC_BITS + 1 > NOISE_BITS + FRAC_BITS) ?
                             ACC_BITS + 1 : NOISE_BITS + FRAC_BITS;
   localparam int RES_BITS = SUM_BITS - FRAC_BITS;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic {
      REG_OCTAVE_COUNT = 1'b0,
      REG_AMP_FALLOFF  = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // Cosine weight ROM: entry k = sin^2(pi k / 2^(B+1)) in Q0.16, from a
   // truncated Q30 Taylor series of the sine.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [63:0] div_list_type [1:7];
   localparam div_list_type TAYLOR_DIV =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

   typedef logic [VALUE_BITS-1:0] cos_rom_type [ROM_DEPTH];

   function automatic cos_rom_type build_cos_rom();
      cos_rom_type        rom;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        sq;
      logic [63:0]        w;
      logic signed [63:0] s;
      int                 k;
      int                 n;
      for (k = 0; k < ROM_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * 64'(k)) >> COS_ROM_BITS;
         x2   = (x * x) >> 30;
         term = x;
         s    = $signed(x);
         for (n = 1; n < 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
               s = s - $signed(term);
            end else begin
               s = s + $signed(term);
            end
         end
         if (s < 0) begin
            s = 64'sd0;
         end
         if (s > (64'sd1 <<< 30)) begin
            s = 64'sd1 <<< 30;
         end
         sq = $unsigned(s) * $unsigned(s);
         w  = (sq + (64'd1 << 43)) >> 44;
         if (w > 64'd65535) begin
            w = 64'd65535;
         end
         rom[k] = w[VALUE_BITS-1:0];
      end
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_cos_rom();

endpackage

`default_nettype wire

FILE: src/octave_value_noise_3d.sv
// ============================================================================
// octave_value_noise_3d: fractal 3D value noise engine
// Loads a value table over the request stream and answers noise queries
// by summing trilinearly blended table lookups over several octaves.
// ============================================================================
//
// Request stream (req_*): tuser carries the opcode. A load transaction writes
// one table entry in its accept cycle and returns nothing; loads can be sent
// back to back. A query transaction returns one noise value on rsp_*.
//
// A load or a query is accepted only when the engine is idle. Each octave
// makes eight reads of the single-port value table, one per cycle, with
// the seven cosine blends sharing one multiplier as the data arrives, then
// a step that accumulates and updates the octave weight. After the last
// octave, a finish state registers the result once the output register is
// free and returns to idle, where the next query may follow.
//
// The result sits in an output register, so a load or a new query is taken
// while a finished result still waits for rsp_tready. A query that finishes
// while that register is still full waits until it drains.
//
// Reset restores octave_count and amp_falloff and empties the pipeline. The
// value table is not cleared; every entry a query touches must be loaded.
// Users write registers over csr_* only with no query in flight; unenforced.

`default_nettype none

module octave_value_noise_3d (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // tdata: table_index[11:0], table_value[27:12], coord_x[59:28],
   //        coord_y[91:60], coord_z[123:92], zero fill[127:124]
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [ovn3d_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // tuser: opcode[0]
   input  wire logic                                 req_tuser,
   // tdata: noise_value[18:0], zero fill[23:19]
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [ovn3d_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ovn3d_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [ovn3d_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ovn3d_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                      csr_pready
);

   import ovn3d_pkg::*;

   // Octave schedule. Reads go out on steps 0..7, data returns on the following
   // step. X blends fire when an odd corner arrives.
   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] STEP_WX   = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_WY   = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_WZ   = 4'd3;
   localparam logic [STEP_BITS-1:0] STEP_BX0  = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_BX1  = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_BY0  = 4'd5;
   localparam logic [STEP_BITS-1:0] STEP_BX2  = 4'd6;
   localparam logic [STEP_BITS-1:0] STEP_BX3  = 4'd8;
   localparam logic [STEP_BITS-1:0] STEP_BY1  = 4'd9;
   localparam logic [STEP_BITS-1:0] STEP_BZ   = 4'd10;
   localparam logic [STEP_BITS-1:0] STEP_ACC  = 4'd11;
   localparam logic [STEP_BITS-1:0] STEP_READ = 4'd8;

   localparam logic [TABLE_ADDR_BITS-1:0] Y_STRIDE = TABLE_ADDR_BITS'(1 << Y_SHIFT);
   localparam logic [TABLE_ADDR_BITS-1:0] Z_STRIDE = TABLE_ADDR_BITS'(1 << Z_SHIFT);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type                     state_ff, state_in;
   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic [OCT_BITS-1:0]           oct_ff, oct_in;
   logic [OCT_BITS-1:0]           octave_count_ff, octave_count_in;
   logic [FALLOFF_BITS-1:0]       amp_falloff_ff, amp_falloff_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [NOISE_BITS-1:0]         noise_ff;

   logic [TABLE_ADDR_BITS-1:0]    xi_ff, yi_ff, zi_ff;
   logic [FRAC_BITS-1:0]          xf_ff, yf_ff, zf_ff;
   logic [VALUE_BITS-1:0]         wx_ff, wy_ff, wz_ff;
   logic [VALUE_BITS-1:0]         even_ff;
   logic [VALUE_BITS-1:0]         nx0_ff, nx1_ff, ny0_ff, ny1_ff, nz_ff;
   logic [VALUE_BITS-1:0]         amp_ff, amp_in;
   logic [ACC_BITS-1:0]           acc_ff;

   logic [VALUE_BITS-1:0]         table_mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0]         table_q_ff;
   logic [VALUE_BITS-1:0]         rom_q_ff;

   // ------------------------------------------------------------------
   // Request unpacking
   // ------------------------------------------------------------------
   logic                          req_fire;
   logic                          mem_we;
   logic                          query_start;
   logic [INDEX_BITS-1:0]         req_table_index;
   logic [VALUE_BITS-1:0]         req_table_value;
   logic [COORD_BITS-1:0]         req_coord_x, req_coord_y, req_coord_z;
   logic [COORD_BITS-1:0]         mag_x, mag_y, mag_z;

   assign req_table_index = req_tdata[IDX_LSB +: INDEX_BITS];
   assign req_table_value = req_tdata[VAL_LSB +: VALUE_BITS];
   assign req_coord_x     = req_tdata[X_LSB +: COORD_BITS];
   assign req_coord_y     = req_tdata[Y_LSB +: COORD_BITS];
   assign req_coord_z     = req_tdata[Z_LSB +: COORD_BITS];

   // The most negative coordinate wraps to 2^31, taken as unsigned.
   assign mag_x = req_coord_x[COORD_BITS-1] ? (~req_coord_x + 1'b1) : req_coord_x;
   assign mag_y = req_coord_y[COORD_BITS-1] ? (~req_coord_y + 1'b1) : req_coord_y;
   assign mag_z = req_coord_z[COORD_BITS-1] ? (~req_coord_z + 1'b1) : req_coord_z;

   assign req_fire    = req_tvalid && req_tready;
   assign mem_we      = req_fire && (req_tuser == OP_LOAD);
   assign query_start = req_fire && (req_tuser == OP_QUERY);

   // ------------------------------------------------------------------
   // Control state machine
   // ------------------------------------------------------------------
   logic last_octave;
   logic out_free;
   logic rsp_load;

   assign last_octave = (oct_ff == octave_count_ff - OCT_BITS'(1));
   assign out_free    = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_ACC && last_octave) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      step_in    = '0;
      oct_in     = oct_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            oct_in     = '0;
         end
         ST_RUN: begin
            if (step_ff == STEP_ACC) begin
               oct_in = oct_ff + OCT_BITS'(1);
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_FINISH: begin
            rsp_load = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         oct_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         oct_ff        <= oct_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic                    csr_write;
   reg_index_type           csr_sel;
   logic [OCT_BITS-1:0]     wr_octaves;
   logic [FALLOFF_BITS-1:0] wr_falloff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = reg_index_type'(csr_paddr[CSR_SEL_BIT]);
   assign wr_octaves = csr_pwdata[OCT_BITS-1:0];
   assign wr_falloff = csr_pwdata[FALLOFF_BITS-1:0];

   always_comb begin
      octave_count_in = octave_count_ff;
      amp_falloff_in  = amp_falloff_ff;
      csr_prdata      = '0;
      unique case (csr_sel)
         REG_OCTAVE_COUNT: begin
            csr_prdata = CSR_DATA_BITS'(octave_count_ff);
            // A zero write is dropped; counts above the limit saturate.
            if (csr_write && wr_octaves != '0) begin
               octave_count_in = (32'(wr_octaves) > MAX_OCTAVES) ?
                                 OCT_BITS'(MAX_OCTAVES) : wr_octaves;
            end
         end
         REG_AMP_FALLOFF: begin
            csr_prdata = CSR_DATA_BITS'(amp_falloff_ff);
            if (csr_write && wr_falloff != '0) begin
               amp_falloff_in = wr_falloff;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= OCT_RESET;
         amp_falloff_ff  <= FALLOFF_RESET;
      end else begin
         octave_count_ff <= octave_count_in;
         amp_falloff_ff  <= amp_falloff_in;
      end
   end

   // ------------------------------------------------------------------
   // Value table (single port) and cosine ROM
   // ------------------------------------------------------------------
   logic [TABLE_ADDR_BITS-1:0] cell_base;
   logic [TABLE_ADDR_BITS-1:0] corner_off;
   logic [TABLE_ADDR_BITS-1:0] mem_addr;
   logic [COS_ROM_BITS-1:0]    rom_addr;

   assign cell_base = xi_ff + TABLE_ADDR_BITS'(yi_ff << Y_SHIFT)
                    + TABLE_ADDR_BITS'(zi_ff << Z_SHIFT);

   // The low three step bits pick the corner: x, y and z neighbor.
   assign corner_off = (step_ff[0] ? TABLE_ADDR_BITS'(1) : '0)
                     + (step_ff[1] ? Y_STRIDE : '0)
                     + (step_ff[2] ? Z_STRIDE : '0);

   assign mem_addr = mem_we ? TABLE_ADDR_BITS'(req_table_index)
                            : cell_base + corner_off;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= req_table_value;
      end
      table_q_ff <= table_mem[mem_addr];
   end

   always_comb begin
      case (step_ff)
         4'd0:    rom_addr = xf_ff[FRAC_BITS-1 -: COS_ROM_BITS];
         4'd1:    rom_addr = yf_ff[FRAC_BITS-1 -: COS_ROM_BITS];
         default: rom_addr = zf_ff[FRAC_BITS-1 -: COS_ROM_BITS];
      endcase
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= COS_ROM[rom_addr];
   end

   // ------------------------------------------------------------------
   // Shared blend unit: a + (b - a) * w, rounded, in Q0.16
   // ------------------------------------------------------------------
   logic [VALUE_BITS-1:0]        blend_a, blend_b, blend_w;
   logic signed [VALUE_BITS:0]   blend_diff;
   logic signed [2*VALUE_BITS+1:0] blend_prod;
   logic signed [2*VALUE_BITS+2:0] blend_sum;
   logic [VALUE_BITS-1:0]        blend_out;

   always_comb begin
      blend_a = even_ff;
      blend_b = table_q_ff;
      blend_w = wx_ff;
      case (step_ff)
         STEP_BY0, STEP_BY1: begin
            blend_a = nx0_ff;
            blend_b = nx1_ff;
            blend_w = wy_ff;
         end
         STEP_BZ: begin
            blend_a = ny0_ff;
            blend_b = ny1_ff;
            blend_w = wz_ff;
         end
         default: begin
            blend_a = even_ff;
         end
      endcase
      blend_diff = $signed({1'b0, blend_b}) - $signed({1'b0, blend_a});
      blend_prod = blend_diff * $signed({1'b0, blend_w});
      blend_sum  = $signed({3'b000, blend_a, {FRAC_BITS{1'b0}}})
                 + (2*VALUE_BITS+3)'(blend_prod)
                 + (2*VALUE_BITS+3)'(32768);
      blend_out  = blend_sum[2*VALUE_BITS-1:FRAC_BITS];
   end

   // ------------------------------------------------------------------
   // Octave weight and accumulation
   // ------------------------------------------------------------------
   logic [2*VALUE_BITS-1:0] acc_prod;
   logic [2*VALUE_BITS-1:0] amp_mul;
   logic [2*VALUE_BITS:0]   amp_rnd;
   logic [SUM_BITS-1:0]     sum_rnd;
   logic [RES_BITS-1:0]     sum_res;
   logic [NOISE_BITS-1:0]   noise_sat;

   assign acc_prod = nz_ff * amp_ff;
   assign amp_mul  = amp_ff * amp_falloff_ff;
   assign amp_rnd  = (2*VALUE_BITS+1)'(amp_mul) + (2*VALUE_BITS+1)'(32768);
   assign amp_in   = amp_rnd[2*VALUE_BITS-1:FRAC_BITS];

   assign sum_rnd   = SUM_BITS'(acc_ff) + SUM_BITS'(32768);
   assign sum_res   = sum_rnd[SUM_BITS-1:FRAC_BITS];
   assign noise_sat = (sum_res > RES_BITS'(NOISE_MAX)) ? NOISE_MAX
                                                       : NOISE_BITS'(sum_res);

   // ------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (query_start) begin
         xi_ff  <= TABLE_ADDR_BITS'(mag_x[COORD_BITS-1:FRAC_BITS]);
         yi_ff  <= TABLE_ADDR_BITS'(mag_y[COORD_BITS-1:FRAC_BITS]);
         zi_ff  <= TABLE_ADDR_BITS'(mag_z[COORD_BITS-1:FRAC_BITS]);
         xf_ff  <= mag_x[FRAC_BITS-1:0];
         yf_ff  <= mag_y[FRAC_BITS-1:0];
         zf_ff  <= mag_z[FRAC_BITS-1:0];
         amp_ff <= AMP_INIT;
         acc_ff <= '0;
      end else if (state_ff == ST_RUN && step_ff == STEP_ACC) begin
         acc_ff <= acc_ff + ACC_BITS'(acc_prod);
         amp_ff <= amp_in;
         // Doubling: the fraction's top bit carries into the integer part.
         xi_ff  <= {xi_ff[TABLE_ADDR_BITS-2:0], xf_ff[FRAC_BITS-1]};
         yi_ff  <= {yi_ff[TABLE_ADDR_BITS-2:0], yf_ff[FRAC_BITS-1]};
         zi_ff  <= {zi_ff[TABLE_ADDR_BITS-2:0], zf_ff[FRAC_BITS-1]};
         xf_ff  <= {xf_ff[FRAC_BITS-2:0], 1'b0};
         yf_ff  <= {yf_ff[FRAC_BITS-2:0], 1'b0};
         zf_ff  <= {zf_ff[FRAC_BITS-2:0], 1'b0};
      end

      if (state_ff == ST_RUN) begin
         if (step_ff == STEP_WX) begin
            wx_ff <= rom_q_ff;
         end
         if (step_ff == STEP_WY) begin
            wy_ff <= rom_q_ff;
         end
         if (step_ff == STEP_WZ) begin
            wz_ff <= rom_q_ff;
         end
         // Even corners arrive on odd steps and wait for their partner.
         if (step_ff[0] && step_ff < STEP_READ) begin
            even_ff <= table_q_ff;
         end
         case (step_ff)
            STEP_BX0, STEP_BX2: nx0_ff <= blend_out;
            STEP_BX1, STEP_BX3: nx1_ff <= blend_out;
            STEP_BY0:           ny0_ff <= blend_out;
            STEP_BY1:           ny1_ff <= blend_out;
            STEP_BZ:            nz_ff  <= blend_out;
            default:            ;
         endcase
      end

      if (rsp_load) begin
         noise_ff <= noise_sat;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(noise_ff);

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_octave_count_range: assert property (@(posedge clock) disable iff (reset)
      (octave_count_ff != '0) && (32'(octave_count_ff) <= MAX_OCTAVES))
      else $error("octave count register left its legal range");

   a_octave_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (oct_ff < octave_count_ff))
      else $error("octave counter ran past the configured count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register overwritten while still pending");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside the finish state");

   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (amp_ff <= AMP_INIT))
      else $error("octave weight grew above its start value");

endmodule

`default_nettype wire

FILE: test/ovn3d_checker.sv
// ----------------------------------------------------------------------------
// ovn3d_checker: prediction and comparison for the octave value noise block
// Watches the request, response and register ports, keeps its own image of
// the value table and of the two registers, computes the noise value of each
// accepted query and compares every returned result against the oldest one.
// ----------------------------------------------------------------------------

module ovn3d_checker
   import ovn3d_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   // tdata: table_index, table_value, coord_x, coord_y, coord_z, zero fill
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // tuser: opcode
   input  wire logic                     req_tuser,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   // tdata: noise_value, zero fill
   input  wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic                     csr_pready,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                            fail_count,
   output int                            pending_count,
   output int                            load_count,
   output int                            query_count,
   output int                            result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          TABLE_ENTRIES     = 4096;
   localparam int          Y_STEP            = 16;
   localparam int          Z_STEP            = 256;
   localparam int          WEIGHT_INDEX_BITS = 10;
   localparam int          WEIGHT_ENTRIES    = 1 << WEIGHT_INDEX_BITS;
   localparam logic [3:0]  OCTAVE_LIMIT      = 4'd8;
   localparam logic [63:0] QUARTER_TURN_Q30  = 64'd1686629713;
   localparam logic [63:0] NOISE_CEILING     = 64'd524287;

   logic [15:0]           table_image [TABLE_ENTRIES];
   logic [15:0]           cosine_weight [WEIGHT_ENTRIES];
   logic [3:0]            octaves_setting;
   logic [15:0]           falloff_setting;
   logic [NOISE_BITS-1:0] expected_noise [$];

   // Weight k is sin^2(pi k / 2^(B+1)) in Q0.16; the sine is a truncated
   // eight-term Taylor series in Q30, clamped to [0, 1].
   initial begin
      longint unsigned angle;
      longint unsigned angle_sq;
      longint unsigned term;
      longint unsigned product;
      longint unsigned rounded;
      longint          sine;
      int              k;
      int              n;
      fail_count    = 0;
      pending_count = 0;
      load_count    = 0;
      query_count   = 0;
      result_count  = 0;
      for (k = 0; k < WEIGHT_ENTRIES; k++) begin
         angle    = (QUARTER_TURN_Q30 * 64'(k)) >> WEIGHT_INDEX_BITS;
         angle_sq = (angle * angle) >> 30;
         term     = angle;
         sine     = longint'(angle);
         for (n = 1; n < 8; n++) begin
            term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sine = sine - longint'(term);
            end else begin
               sine = sine + longint'(term);
            end
         end
         if (sine < 0) begin
            sine = 0;
         end
         if (sine > (64'sd1 <<< 30)) begin
            sine = 64'sd1 <<< 30;
         end
         product = 64'(sine) * 64'(sine);
         rounded = (product + (64'd1 << 43)) >> 44;
         if (rounded > 64'd65535) begin
            rounded = 64'd65535;
         end
         cosine_weight[k] = rounded[15:0];
      end
   end

   function automatic logic [15:0] mix_q16(logic [15:0] a, logic [15:0] b, logic [15:0] w);
      logic [63:0] t;
      t = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w) + 64'd32768;
      return t[31:16];
   endfunction

   function automatic logic [NOISE_BITS-1:0] predict_noise(logic [31:0] cx, logic [31:0] cy,
                                                           logic [31:0] cz);
      logic [31:0] coord [3];
      logic [31:0] lattice [3];
      logic [15:0] frac [3];
      logic [15:0] wgt [3];
      logic [15:0] corner [8];
      logic [31:0] mag;
      logic [31:0] base;
      logic [31:0] addr;
      logic [15:0] near_plane;
      logic [15:0] far_plane;
      logic [15:0] blended;
      logic [15:0] amp;
      logic [63:0] acc;
      logic [63:0] rounded;
      int          a;
      int          c;
      int          o;
      coord[0] = cx;
      coord[1] = cy;
      coord[2] = cz;
      for (a = 0; a < 3; a++) begin
         // The most negative coordinate keeps magnitude 2^31 as unsigned.
         mag        = coord[a][31] ? -coord[a] : coord[a];
         lattice[a] = {16'd0, mag[31:16]};
         frac[a]    = mag[15:0];
      end
      amp = 16'd32768;
      acc = '0;
      for (o = 0; o < int'(octaves_setting); o++) begin
         base = lattice[0] + (lattice[1] * Y_STEP) + (lattice[2] * Z_STEP);
         for (a = 0; a < 3; a++) begin
            wgt[a] = cosine_weight[frac[a] >> (16 - WEIGHT_INDEX_BITS)];
         end
         for (c = 0; c < 8; c++) begin
            addr = base + ((c & 1) ? 1 : 0) + ((c & 2) ? Y_STEP : 0) + ((c & 4) ? Z_STEP : 0);
            corner[c] = table_image[addr & (TABLE_ENTRIES - 1)];
         end
         near_plane = mix_q16(mix_q16(corner[0], corner[1], wgt[0]),
                              mix_q16(corner[2], corner[3], wgt[0]), wgt[1]);
         far_plane  = mix_q16(mix_q16(corner[4], corner[5], wgt[0]),
                              mix_q16(corner[6], corner[7], wgt[0]), wgt[1]);
         blended    = mix_q16(near_plane, far_plane, wgt[2]);
         acc = acc + 64'(blended) * 64'(amp);
         amp = 16'((32'(amp) * 32'(falloff_setting) + 32'd32768) >> 16);
         // Doubling carries the top fraction bit into the integer part.
         for (a = 0; a < 3; a++) begin
            lattice[a] = {lattice[a][30:0], frac[a][15]};
            frac[a]    = {frac[a][14:0], 1'b0};
         end
      end
      rounded = (acc + 64'd32768) >> 16;
      if (rounded > NOISE_CEILING) begin
         rounded = NOISE_CEILING;
      end
      return rounded[NOISE_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      logic [NOISE_BITS-1:0] want;
      logic [NOISE_BITS-1:0] got;
      logic [3:0]            octave_word;
      logic [15:0]           falloff_word;
      if (reset) begin
         octaves_setting = 4'd4;
         falloff_setting = 16'd32768;
         expected_noise.delete();
         pending_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            octave_word  = csr_pwdata[3:0];
            falloff_word = csr_pwdata[15:0];
            // A zero write leaves the register unchanged.
            case (reg_index_type'(csr_paddr[2]))
               REG_OCTAVE_COUNT: begin
                  if (octave_word != 4'd0) begin
                     octaves_setting = (octave_word > OCTAVE_LIMIT) ? OCTAVE_LIMIT : octave_word;
                  end
               end
               REG_AMP_FALLOFF: begin
                  if (falloff_word != 16'd0) begin
                     falloff_setting = falloff_word;
                  end
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[NOISE_BITS-1:0];
            result_count++;
            if (expected_noise.size() == 0) begin
               $error("unexpected response transaction: noise_value %0d", got);
               fail_count++;
            end else begin
               want = expected_noise.pop_front();
               if (got !== want) begin
                  $error("noise_value mismatch: expected %0d, actual %0d", want, got);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (opcode_type'(req_tuser) == OP_LOAD) begin
               table_image[req_tdata[IDX_LSB +: INDEX_BITS]] = req_tdata[VAL_LSB +: VALUE_BITS];
               load_count++;
            end else begin
               expected_noise.push_back(predict_noise(req_tdata[X_LSB +: COORD_BITS],
                                                      req_tdata[Y_LSB +: COORD_BITS],
                                                      req_tdata[Z_LSB +: COORD_BITS]));
               query_count++;
            end
         end
         pending_count = expected_noise.size();
      end
   end

endmodule

FILE: test/tb_octave_value_noise_3d.sv
// ----------------------------------------------------------------------------
// tb_octave_value_noise_3d: stimulus and verdict for the octave value noise block
// Fills the whole value table, runs directed corner queries, then random
// loads and queries under several register settings with random stalls on
// both streams. Checking is done by the checker module beside the block.
// ----------------------------------------------------------------------------

module tb_octave_value_noise_3d
   import ovn3d_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int SETTLE_CYCLES   = 12 * 8 + 20;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int LONG_HOLD       = 400;
   localparam int DIRECTED_LOADS  = 7;
   localparam int DIRECTED_QUERIES = 9;

   localparam logic [31:0] SPECIAL_COORDS [7] = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
      32'h0000_FFFF, 32'h0000_8000, 32'h0001_0000
   };
   localparam logic [11:0] LOAD_INDEX [DIRECTED_LOADS] = '{
      12'd0, 12'd1, 12'd16, 12'd17, 12'd256, 12'd4095, 12'd4094
   };
   localparam logic [15:0] LOAD_VALUE [DIRECTED_LOADS] = '{
      16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000
   };
   localparam logic [31:0] QUERY_X [DIRECTED_QUERIES] = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_8000,
      32'h0000_FFFF, 32'h000F_0000, 32'hFFF1_0000, 32'h0001_0000
   };
   localparam logic [31:0] QUERY_Y [DIRECTED_QUERIES] = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_8000,
      32'h0000_0000, 32'h000F_0000, 32'h000F_8000, 32'h0001_0000
   };
   localparam logic [31:0] QUERY_Z [DIRECTED_QUERIES] = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_8000,
      32'h8000_0000, 32'h000F_0000, 32'h0001_0000, 32'h0001_0000
   };

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int   fail_count;
   int   pending_count;
   int   load_count;
   int   query_count;
   int   result_count;

   logic send_idling   = 1'b0;
   logic rsp_idling    = 1'b0;
   int   hold_requests = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   octave_value_noise_3d uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ovn3d_checker noise_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .load_count    (load_count),
      .query_count   (query_count),
      .result_count  (result_count)
   );

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return $urandom_range(1, 2);
      end
      if (r < 95) begin
         return $urandom_range(3, 8);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] random_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 16'h0000;
      end
      if (r == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   // Small magnitudes keep the integer lattice coordinates small.
   function automatic logic [31:0] random_coord();
      int          r;
      logic [31:0] mag;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return $urandom;
      end
      if (r < 80) begin
         mag = $urandom_range(0, 32'h001F_FFFF);
         return ($urandom_range(0, 1) == 1) ? -mag : mag;
      end
      return SPECIAL_COORDS[$urandom_range(0, 6)];
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic push_item(opcode_type op, logic [11:0] idx, logic [15:0] val,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [REQ_DATA_BITS-1:0] word;
      word = '0;
      word[IDX_LSB +: INDEX_BITS] = idx;
      word[VAL_LSB +: VALUE_BITS] = val;
      word[X_LSB +: COORD_BITS]   = x;
      word[Y_LSB +: COORD_BITS]   = y;
      word[Z_LSB +: COORD_BITS]   = z;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic push_query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      push_item(OP_QUERY, 12'($urandom), 16'($urandom), x, y, z);
   endtask

   task automatic sender_pause();
      int n;
      if (send_idling && $urandom_range(0, 99) < 30) begin
         n = gap_length();
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic random_item();
      if ($urandom_range(0, 99) < 40) begin
         push_item(OP_LOAD, 12'($urandom), random_value(), $urandom, $urandom, $urandom);
      end else begin
         push_query(random_coord(), random_coord(), random_coord());
      end
      sender_pause();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_count != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic csr_write(reg_index_type which, logic [31:0] word);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      int served;
      rsp_tready = 1'b0;
      hold_left  = 0;
      served     = 0;
      forever begin
         @(negedge clock);
         if (served != hold_requests) begin
            served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left == 0 && rsp_idling && $urandom_range(0, 99) < 25) begin
            hold_left = gap_length();
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #10ms;
      $error("simulation time limit reached with %0d results outstanding", pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [31:0] octave_words [PHASES];
      logic [31:0] falloff_words [PHASES];
      int          p;
      int          i;
      int          waited;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_LOAD;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      // Extremes first, then ignored zero writes (with junk in the upper
      // bits), an oversized octave count, and two random settings.
      octave_words  = '{32'h0000_0001, 32'h0000_0008, 32'hABCD_EF00,
                        32'h1234_567F, 32'h0, 32'h0};
      falloff_words = '{32'h0000_FFFF, 32'h0000_0001, 32'hFFFF_0000,
                        32'h00FF_8001, 32'h0, 32'h0};
      octave_words[4]  = {$urandom, 4'($urandom_range(1, 15))};
      falloff_words[4] = {16'($urandom), 16'($urandom_range(1, 65535))};
      octave_words[5]  = 32'($urandom_range(5, 15));
      falloff_words[5] = 32'($urandom_range(1, 65535));

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every entry is written before any query can read it.
      for (i = 0; i < 4096; i++) begin
         push_item(OP_LOAD, 12'(i), random_value(), $urandom, $urandom, $urandom);
      end

      for (i = 0; i < DIRECTED_LOADS; i++) begin
         push_item(OP_LOAD, LOAD_INDEX[i], LOAD_VALUE[i], $urandom, $urandom, $urandom);
      end
      for (i = 0; i < DIRECTED_QUERIES; i++) begin
         push_query(QUERY_X[i], QUERY_Y[i], QUERY_Z[i]);
      end

      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(negedge clock);
         csr_write(REG_OCTAVE_COUNT, octave_words[p]);
         csr_write(REG_AMP_FALLOFF, falloff_words[p]);
         send_idling = (p != 0);
         rsp_idling <= (p != 0);
         if (p == 1) begin
            // Queries keep coming while the response side is held off.
            hold_requests <= hold_requests + 1;
            for (i = 0; i < 16; i++) begin
               push_query(random_coord(), random_coord(), random_coord());
            end
         end
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == 3 && i == ITEMS_PER_PHASE / 2) begin
               wait_drained();
            end
            random_item();
         end
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_count != 0) begin
         $error("%0d expected noise results never arrived", pending_count);
      end

      $display("Run covered %0d table loads and %0d noise queries, %0d results compared,",
               load_count, query_count, result_count);
      $display("over %0d register settings from one to eight octaves and falloff 1 to 65535.",
               PHASES + 1);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
src/ovn3d_pkg.sv
src/octave_value_noise_3d.sv
test/ovn3d_checker.sv
test/tb_octave_value_noise_3d.sv
